FILE: rtl/stma_pkg.sv
// shared types and constants for the sparse triplet matrix add unit
// no dependencies
package stma_pkg;

    localparam int TripletW = 32;
    localparam int KeyW     = 16;
    localparam int ValW     = 16;
    localparam int SumW     = 17;
    localparam int DimW     = 9;
    localparam int CmdW     = 2;
    localparam int RegIdxW  = 1;

    typedef logic [CmdW-1:0] cmd_t;

    localparam cmd_t CmdLoadA = 2'd0;
    localparam cmd_t CmdLoadB = 2'd1;
    localparam cmd_t CmdRun   = 2'd2;
    localparam cmd_t CmdNone  = 2'd3;

    localparam logic [RegIdxW-1:0] RegRows = 1'd0;
    localparam logic [RegIdxW-1:0] RegCols = 1'd1;

    typedef struct packed {
        logic            start;
        logic            dropped;
        logic [DimW-1:0] rows;
        logic [DimW-1:0] cols;
    } run_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } run_sts_t;

endpackage

FILE: rtl/stma_if.sv
// valid/ready channel interfaces: entry input, result output, register write
// depends on stma_pkg
interface stma_entry_if;
    import stma_pkg::*;
    logic              valid;
    logic              ready;
    cmd_t              cmd;
    logic [7:0]        entry_row;
    logic [7:0]        entry_col;
    logic signed [15:0] entry_value;

    modport source (output valid, cmd, entry_row, entry_col, entry_value, input ready);
    modport sink (input valid, cmd, entry_row, entry_col, entry_value, output ready);
endinterface

interface stma_result_if;
    import stma_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   is_trailer;
    logic [DimW-1:0]        out_row;
    logic [DimW-1:0]        out_col;
    logic signed [SumW-1:0] out_value;
    logic                   overflow;
    logic                   last;

    modport source (output valid, is_trailer, out_row, out_col, out_value, overflow, last,
                    input ready);
    modport sink (input valid, is_trailer, out_row, out_col, out_value, overflow, last,
                  output ready);
endinterface

interface stma_cfg_if;
    import stma_pkg::*;
    logic               valid;
    logic               ready;
    logic [RegIdxW-1:0] index;
    logic [DimW-1:0]    wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface

FILE: rtl/stma_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module stma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/stma_merge.sv
// merge sequencer: walks both triplet lists, sums matched positions, emits words
// and the trailer through an output register; depends on stma_pkg, stma_if
module stma_merge #(
    parameter int LIST_CAPACITY = 16,
    localparam int AddrW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1,
    localparam int CntW  = $clog2(LIST_CAPACITY + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  stma_pkg::run_ctl_t         ctl,
    output stma_pkg::run_sts_t         sts,
    input  logic [CntW-1:0]            cnt_a,
    input  logic [CntW-1:0]            cnt_b,
    output logic [AddrW-1:0]           raddr_a,
    output logic [AddrW-1:0]           raddr_b,
    input  logic [stma_pkg::TripletW-1:0] rdata_a,
    input  logic [stma_pkg::TripletW-1:0] rdata_b,
    stma_result_if.source              result
);
    import stma_pkg::*;

    localparam int NumW = $clog2(2 * LIST_CAPACITY + 1);

    localparam logic StIdle = 1'b0;
    localparam logic StRun  = 1'b1;

    logic            state_reg, state_next;
    logic [CntW-1:0] pa_reg, pa_next;
    logic [CntW-1:0] pb_reg, pb_next;
    logic [NumW-1:0] num_reg, num_next;

    logic                   valid_reg, valid_next;
    logic                   trailer_reg, trailer_next;
    logic [DimW-1:0]        row_reg, row_next;
    logic [DimW-1:0]        col_reg, col_next;
    logic signed [SumW-1:0] value_reg, value_next;
    logic                   ovf_reg, ovf_next;

    logic                   a_av, b_av, take_a, take_b, emit, finish, can_emit, step;
    logic [KeyW-1:0]        key_a, key_b, key_sel;
    logic signed [SumW-1:0] val_a, val_b, sum, val_sel;

    assign key_a    = rdata_a[TripletW-1 -: KeyW];
    assign key_b    = rdata_b[TripletW-1 -: KeyW];
    assign val_a    = SumW'($signed(rdata_a[ValW-1:0]));
    assign val_b    = SumW'($signed(rdata_b[ValW-1:0]));
    assign sum      = val_a + val_b;
    assign a_av     = pa_reg < cnt_a;
    assign b_av     = pb_reg < cnt_b;
    assign can_emit = !valid_reg || result.ready;
    assign step     = (state_reg == StRun) && can_emit;

    always_comb
    begin
        take_a  = 1'b0;
        take_b  = 1'b0;
        emit    = 1'b0;
        finish  = 1'b0;
        key_sel = key_a;
        val_sel = val_a;
        priority if (a_av && b_av)
        begin
            if (key_a == key_b)
            begin
                take_a  = 1'b1;
                take_b  = 1'b1;
                emit    = (sum != '0);
                val_sel = sum;
            end
            else if (key_a < key_b)
            begin
                take_a = 1'b1;
                emit   = 1'b1;
            end
            else
            begin
                take_b  = 1'b1;
                emit    = 1'b1;
                key_sel = key_b;
                val_sel = val_b;
            end
        end
        else if (a_av)
        begin
            take_a = 1'b1;
            emit   = 1'b1;
        end
        else if (b_av)
        begin
            take_b  = 1'b1;
            emit    = 1'b1;
            key_sel = key_b;
            val_sel = val_b;
        end
        else
        begin
            finish = 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        num_next     = num_reg;
        valid_next   = valid_reg && !result.ready;
        trailer_next = trailer_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        value_next   = value_reg;
        ovf_next     = ovf_reg;
        unique case (state_reg)
            StIdle:
            begin
                pa_next  = '0;
                pb_next  = '0;
                num_next = '0;
                if (ctl.start)
                begin
                    state_next = StRun;
                end
            end
            StRun:
            begin
                if (step)
                begin
                    if (take_a)
                    begin
                        pa_next = pa_reg + 1'b1;
                    end
                    if (take_b)
                    begin
                        pb_next = pb_reg + 1'b1;
                    end
                    if (emit)
                    begin
                        num_next     = num_reg + 1'b1;
                        valid_next   = 1'b1;
                        trailer_next = 1'b0;
                        row_next     = {1'b0, key_sel[KeyW-1 -: 8]};
                        col_next     = {1'b0, key_sel[7:0]};
                        value_next   = val_sel;
                        ovf_next     = 1'b0;
                    end
                    if (finish)
                    begin
                        state_next   = StIdle;
                        pa_next      = '0;
                        pb_next      = '0;
                        num_next     = '0;
                        valid_next   = 1'b1;
                        trailer_next = 1'b1;
                        row_next     = ctl.rows;
                        col_next     = ctl.cols;
                        value_next   = SumW'(num_reg);
                        ovf_next     = ctl.dropped;
                    end
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            pa_reg    <= '0;
            pb_reg    <= '0;
            num_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            num_reg   <= num_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trailer_reg <= trailer_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        value_reg   <= value_next;
        ovf_reg     <= ovf_next;
    end

    // read address follows the next pointer so data lines up with the pointer
    assign raddr_a = pa_next[AddrW-1:0];
    assign raddr_b = pb_next[AddrW-1:0];

    assign sts.idle = (state_reg == StIdle);
    assign sts.done = step && finish;

    assign result.valid      = valid_reg;
    assign result.is_trailer = trailer_reg;
    assign result.out_row    = row_reg;
    assign result.out_col    = col_reg;
    assign result.out_value  = value_reg;
    assign result.overflow   = ovf_reg;
    assign result.last       = trailer_reg;

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pa_reg <= cnt_a) && (pb_reg <= cnt_b))
        else $error("merge pointer ran past list count");

    a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
        NumW'(num_reg) <= NumW'(pa_reg) + NumW'(pb_reg))
        else $error("more words emitted than entries consumed");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |=> (state_reg == StIdle) && valid_reg && trailer_reg)
        else $error("run end did not leave a trailer in the output register");

    a_idle_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StIdle) |-> (pa_reg == '0) && (pb_reg == '0) && (num_reg == '0))
        else $error("pointers not cleared while idle");

endmodule

FILE: rtl/sparse_triplet_matrix_add_unit.sv
// top level of the sparse triplet matrix add unit: load control, list counts,
// size registers, two list rams and the merge sequencer; depends on stma_pkg, stma_if,
// stma_ram, stma_merge
//
//  channel  dir  contents
//  entry    in   cmd, entry_row, entry_col, entry_value
//  result   out  is_trailer, out_row, out_col, out_value, overflow, last
//  cfg      in   index, wdata (matrix_rows, matrix_cols)
//
// a run is an accepted run command, the merge steps and a trailer; a step takes one
// list entry, or one entry from each list on a shared position,
// so at most 2*LIST_CAPACITY steps; the ram address comes from the next pointer
// entry.ready is low while a run is in progress; result stalls hold the run
// reset empties both lists and sets the size registers to 1; no clearing pass
module sparse_triplet_matrix_add_unit #(
    parameter int LIST_CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    stma_entry_if.sink    entry,
    stma_result_if.source result,
    stma_cfg_if.sink      cfg
);
    import stma_pkg::*;

    localparam int AddrW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam int CntW  = $clog2(LIST_CAPACITY + 1);

    logic [CntW-1:0] cnt_a_reg, cnt_a_next;
    logic [CntW-1:0] cnt_b_reg, cnt_b_next;
    logic            drop_reg, drop_next;
    logic [DimW-1:0] rows_reg, cols_reg;

    logic                 acc, we_a, we_b, full_a, full_b;
    logic [TripletW-1:0]  wdata;
    logic [AddrW-1:0]     raddr_a, raddr_b;
    logic [TripletW-1:0]  rdata_a, rdata_b;
    run_ctl_t             ctl;
    run_sts_t             sts;

    assign entry.ready = sts.idle;
    assign cfg.ready   = 1'b1;

    assign acc    = entry.valid && entry.ready;
    assign full_a = (cnt_a_reg == CntW'(LIST_CAPACITY));
    assign full_b = (cnt_b_reg == CntW'(LIST_CAPACITY));
    assign we_a   = acc && (entry.cmd == CmdLoadA) && !full_a;
    assign we_b   = acc && (entry.cmd == CmdLoadB) && !full_b;
    assign wdata  = {entry.entry_row, entry.entry_col, entry.entry_value};

    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        drop_next  = drop_reg;
        if (sts.done)
        begin
            cnt_a_next = '0;
            cnt_b_next = '0;
            drop_next  = 1'b0;
        end
        else if (acc)
        begin
            unique case (entry.cmd)
                CmdLoadA:
                begin
                    if (full_a)
                        drop_next = 1'b1;
                    else
                        cnt_a_next = cnt_a_reg + 1'b1;
                end
                CmdLoadB:
                begin
                    if (full_b)
                        drop_next = 1'b1;
                    else
                        cnt_b_next = cnt_b_reg + 1'b1;
                end
                CmdRun, CmdNone:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            drop_reg  <= 1'b0;
            rows_reg  <= DimW'(1);
            cols_reg  <= DimW'(1);
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            drop_reg  <= drop_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    RegRows: rows_reg <= cfg.wdata;
                    RegCols: cols_reg <= cfg.wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign ctl.start   = acc && (entry.cmd == CmdRun);
    assign ctl.dropped = drop_reg;
    assign ctl.rows    = rows_reg;
    assign ctl.cols    = cols_reg;

    stma_ram #(
        .WIDTH (TripletW),
        .DEPTH (LIST_CAPACITY)
    ) u_list_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cnt_a_reg[AddrW-1:0]),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    stma_ram #(
        .WIDTH (TripletW),
        .DEPTH (LIST_CAPACITY)
    ) u_list_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cnt_b_reg[AddrW-1:0]),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    stma_merge #(
        .LIST_CAPACITY (LIST_CAPACITY)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .sts     (sts),
        .cnt_a   (cnt_a_reg),
        .cnt_b   (cnt_b_reg),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .result  (result)
    );

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= CntW'(LIST_CAPACITY)) && (cnt_b_reg <= CntW'(LIST_CAPACITY)))
        else $error("list count beyond capacity");

    a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (we_a || we_b) |-> sts.idle)
        else $error("list write during a run");

    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |=> (cnt_a_reg == '0) && (cnt_b_reg == '0) && !drop_reg)
        else $error("lists not emptied after run");

endmodule

FILE: tb/sv/tb_sparse_triplet_matrix_add_unit.sv
// self-checking testbench for sparse_triplet_matrix_add_unit: directed and random triplet
// loads and merge runs, checked against an in-bench merge predictor
// depends on stma_pkg, stma_if and the rtl of the unit
module tb_sparse_triplet_matrix_add_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import stma_pkg::*;

    localparam int ListCap      = 16;
    localparam int SettleCycles = 2 * ListCap + 8;
    localparam int LongHold     = 300;
    localparam int IdleLimit    = 2000;
    localparam int ItemTarget   = 300;
    localparam int NumPhases    = 6;

    typedef struct {
        cmd_t                   cmd;
        logic [7:0]             row;
        logic [7:0]             col;
        logic signed [ValW-1:0] value;
    } word_t;

    typedef struct {
        logic [KeyW-1:0]        key;
        logic signed [ValW-1:0] value;
    } triplet_t;

    typedef struct {
        logic                   is_trailer;
        logic [DimW-1:0]        row;
        logic [DimW-1:0]        col;
        logic signed [SumW-1:0] value;
        logic                   overflow;
        logic                   last;
    } result_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    stma_entry_if  ent_if ();
    stma_result_if res_if ();
    stma_cfg_if    cfg_if ();

    sparse_triplet_matrix_add_unit #(
        .LIST_CAPACITY(ListCap)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .entry (ent_if.sink),
        .result(res_if.source),
        .cfg   (cfg_if.sink)
    );

    always #5 clk = ~clk;

    // predictor state
    triplet_t        tri_a [ListCap];
    triplet_t        tri_b [ListCap];
    int              cnt_a     = 0;
    int              cnt_b     = 0;
    logic            drop_seen = 1'b0;
    logic [DimW-1:0] rows_cfg  = 9'd1;
    logic [DimW-1:0] cols_cfg  = 9'd1;

    word_t        pending_q[$];
    result_word_t merged_q[$];

    int err_cnt     = 0;
    int stim_count  = 0;
    int n_loads     = 0;
    int n_runs      = 0;
    int n_results   = 0;
    int n_drops     = 0;
    int n_cfg       = 0;
    int send_gap    = 0;
    int take_gap    = 0;
    bit send_burst  = 1'b0;
    bit take_burst  = 1'b0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int idle_cycles = 0;

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic push_merged(logic [KeyW-1:0] key, logic signed [SumW-1:0] total);
        result_word_t r;
        r.is_trailer = 1'b0;
        r.row        = {1'b0, key[15:8]};
        r.col        = {1'b0, key[7:0]};
        r.value      = total;
        r.overflow   = 1'b0;
        r.last       = 1'b0;
        merged_q.push_back(r);
    endtask

    task automatic predict_merge();
        int                     ia;
        int                     ib;
        int                     n;
        logic signed [SumW-1:0] total;
        result_word_t           tr;
        ia = 0;
        ib = 0;
        n  = 0;
        while (ia < cnt_a || ib < cnt_b) begin
            if (ia < cnt_a && ib < cnt_b && tri_a[ia].key == tri_b[ib].key) begin
                total = tri_a[ia].value + tri_b[ib].value;
                if (total != 0) begin
                    push_merged(tri_a[ia].key, total);
                    n++;
                end
                ia++;
                ib++;
            end
            else if (ib >= cnt_b || (ia < cnt_a && tri_a[ia].key < tri_b[ib].key)) begin
                push_merged(tri_a[ia].key, tri_a[ia].value);
                n++;
                ia++;
            end
            else begin
                push_merged(tri_b[ib].key, tri_b[ib].value);
                n++;
                ib++;
            end
        end
        tr.is_trailer = 1'b1;
        tr.row        = rows_cfg;
        tr.col        = cols_cfg;
        tr.value      = SumW'(n);
        tr.overflow   = drop_seen;
        tr.last       = 1'b1;
        merged_q.push_back(tr);
        cnt_a     = 0;
        cnt_b     = 0;
        drop_seen = 1'b0;
    endtask

    task automatic absorb_word(word_t w);
        triplet_t t;
        t.key   = {w.row, w.col};
        t.value = w.value;
        case (w.cmd)
            CmdLoadA: begin
                n_loads++;
                if (cnt_a < ListCap) begin
                    tri_a[cnt_a] = t;
                    cnt_a++;
                end
                else begin
                    drop_seen = 1'b1;
                    n_drops++;
                end
            end
            CmdLoadB: begin
                n_loads++;
                if (cnt_b < ListCap) begin
                    tri_b[cnt_b] = t;
                    cnt_b++;
                end
                else begin
                    drop_seen = 1'b1;
                    n_drops++;
                end
            end
            CmdRun: begin
                n_runs++;
                predict_merge();
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge clk) begin
        bit busy;
        int gap;
        if (rst_n) begin
            busy = ent_if.valid;
            gap  = send_gap;
            if (ent_if.valid && ent_if.ready) begin
                absorb_word(pending_q.pop_front());
                if ($urandom_range(0, 19) == 0)
                    send_burst = !send_burst;
                gap  = draw_gap(send_burst);
                busy = 1'b0;
            end
            else if (!busy && gap > 0) begin
                gap--;
            end
            if (!busy && gap == 0 && pending_q.size() > 0) begin
                ent_if.cmd         <= pending_q[0].cmd;
                ent_if.entry_row   <= pending_q[0].row;
                ent_if.entry_col   <= pending_q[0].col;
                ent_if.entry_value <= pending_q[0].value;
                busy = 1'b1;
            end
            ent_if.valid <= busy;
            send_gap     <= gap;
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= LongHold;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic check_word();
        result_word_t want;
        if (merged_q.size() == 0) begin
            report("unexpected word, out_value", res_if.out_value, 0);
            return;
        end
        want = merged_q.pop_front();
        n_results++;
        if (res_if.is_trailer !== want.is_trailer)
            report("is_trailer", res_if.is_trailer, want.is_trailer);
        if (res_if.out_row !== want.row)
            report("out_row", res_if.out_row, want.row);
        if (res_if.out_col !== want.col)
            report("out_col", res_if.out_col, want.col);
        if (res_if.out_value !== want.value)
            report("out_value", res_if.out_value, want.value);
        if (res_if.overflow !== want.overflow)
            report("overflow", res_if.overflow, want.overflow);
        if (res_if.last !== want.last)
            report("last", res_if.last, want.last);
    endtask

    // monitor
    always @(posedge clk) begin
        int gap;
        if (rst_n) begin
            gap = take_gap;
            if (res_if.valid && res_if.ready) begin
                check_word();
                if ($urandom_range(0, 19) == 0)
                    take_burst = !take_burst;
                gap = draw_gap(take_burst);
            end
            else if (!res_if.ready && gap > 0) begin
                gap--;
            end
            res_if.ready <= (gap == 0) && (hold_left == 0);
            take_gap     <= gap;
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((ent_if.valid && ent_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IdleLimit) begin
                $display("timeout after %0d cycles without a handshake", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic word_t make_word(cmd_t c, logic [KeyW-1:0] key,
                                        logic signed [ValW-1:0] v);
        word_t w;
        w.cmd   = c;
        w.row   = key[15:8];
        w.col   = key[7:0];
        w.value = v;
        return w;
    endfunction

    task automatic push_word(word_t w);
        pending_q.push_back(w);
        if (w.cmd != CmdNone)
            stim_count++;
    endtask

    task automatic push_run();
        push_word(make_word(CmdRun, KeyW'($urandom), ValW'($urandom)));
    endtask

    function automatic logic signed [ValW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            default: return ValW'($urandom);
        endcase
    endfunction

    // sorted lists with shared positions, some of them cancelling
    task automatic queue_sorted_case(int n_keys);
        word_t                  a_side[$];
        word_t                  b_side[$];
        word_t                  w;
        int unsigned            key;
        int                     pick;
        logic signed [ValW-1:0] va;
        key = $urandom_range(0, 65535 - 4 * n_keys - 4);
        for (int i = 0; i < n_keys; i++) begin
            key += $urandom_range(1, 4);
            pick = $urandom_range(0, 5);
            va   = pick_value();
            w    = make_word(CmdLoadA, key[15:0], va);
            if (pick != 2 && pick != 3)
                a_side.push_back(w);
            if (pick >= 2) begin
                w.cmd   = CmdLoadB;
                w.value = (pick == 5) ? -va : pick_value();
                b_side.push_back(w);
            end
        end
        while (a_side.size() + b_side.size() > 0) begin
            if (b_side.size() == 0 || (a_side.size() > 0 && $urandom_range(0, 1)))
                push_word(a_side.pop_front());
            else
                push_word(b_side.pop_front());
        end
        push_run();
    endtask

    task automatic queue_overfill_case();
        cmd_t        c;
        int          n;
        int unsigned key;
        c   = $urandom_range(0, 1) ? CmdLoadB : CmdLoadA;
        n   = $urandom_range(ListCap, ListCap + 4);
        key = $urandom_range(0, 65535 - 4 * n - 4);
        for (int i = 0; i < n; i++) begin
            key += $urandom_range(1, 4);
            push_word(make_word(c, key[15:0], pick_value()));
        end
        push_run();
    endtask

    task automatic queue_noise_case();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            push_word(make_word(cmd_t'($urandom_range(0, 3)), KeyW'($urandom),
                                ValW'($urandom)));
        push_run();
    endtask

    task automatic write_reg(logic [RegIdxW-1:0] idx, logic [DimW-1:0] data);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx == RegRows)
            rows_cfg = data;
        else
            cols_cfg = data;
        n_cfg++;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || merged_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic queue_directed();
        push_run();
        push_word(make_word(CmdNone, 16'hffff, -16'sd1));
        push_word(make_word(CmdLoadA, 16'h0000, 16'sh8000));
        push_word(make_word(CmdLoadA, 16'h0001, 16'sd0));
        push_word(make_word(CmdLoadA, 16'h0005, 16'sd0));
        for (int i = 0; i < 11; i++)
            push_word(make_word(CmdLoadA, KeyW'(16'h0100 + i * 16'h1357),
                                (i % 2) ? 16'shaaaa : 16'sh5555));
        push_word(make_word(CmdLoadA, 16'h0003, 16'sd1234));
        push_word(make_word(CmdLoadA, 16'hffff, 16'sh7fff));
        push_word(make_word(CmdLoadA, 16'hffff, 16'sd1));
        push_word(make_word(CmdLoadB, 16'h0000, 16'sh8000));
        push_word(make_word(CmdLoadB, 16'h0001, 16'sd0));
        push_word(make_word(CmdLoadB, 16'h0100, -16'sh5555));
        push_word(make_word(CmdLoadB, 16'h8000, -16'sd1));
        push_word(make_word(CmdLoadB, 16'hffff, 16'sh7fff));
        push_run();
    endtask

    initial begin
        logic [DimW-1:0] rows_set [NumPhases];
        logic [DimW-1:0] cols_set [NumPhases];
        rows_set = '{9'd256, 9'd0, 9'd511, 9'd1, DimW'($urandom), DimW'($urandom)};
        cols_set = '{9'd0, 9'd511, 9'd256, 9'd1, DimW'($urandom), DimW'($urandom)};

        ent_if.valid       = 1'b0;
        ent_if.cmd         = CmdNone;
        ent_if.entry_row   = '0;
        ent_if.entry_col   = '0;
        ent_if.entry_value = '0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = RegRows;
        cfg_if.wdata       = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        wait_drained();

        for (int p = 0; p < NumPhases; p++) begin
            write_reg(RegRows, rows_set[p]);
            write_reg(RegCols, cols_set[p]);
            if (p == 2)
                hold_req++;
            while (stim_count < ItemTarget * (p + 1) / NumPhases) begin
                case ($urandom_range(0, 9))
                    7, 8:    queue_noise_case();
                    9:       queue_overfill_case();
                    default: queue_sorted_case(($urandom_range(0, 5) == 0) ?
                                               $urandom_range(10, 24) : $urandom_range(0, 10));
                endcase
            end
            wait_drained();
        end

        if (merged_q.size() != 0)
            report("words still expected", 0, merged_q.size());
        $display("covered %0d loads (%0d dropped at capacity), %0d merge runs, %0d register writes",
                 n_loads, n_drops, n_runs, n_cfg);
        $display("checked %0d result words field by field", n_results);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
